// File: src/gpdd_pkg.sv
// gpdd_pkg: shared widths, codes and the result record of the pixel delta decoder
// no dependencies; imported by gpdd_result_fifo and genesis_pixel_delta_decoder_top
package gpdd_pkg;

    localparam int DIM_W      = 13;
    localparam int PIX_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int OP_W       = 2;
    localparam int CMODE_W    = 3;
    localparam int CFG_IDX_W  = 2;

    // result queue, depth is a power of two
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // item opcodes
    localparam logic [OP_W-1:0] OP_IMAGE_START = 2'd0;
    localparam logic [OP_W-1:0] OP_ROW_START   = 2'd1;
    localparam logic [OP_W-1:0] OP_DATA        = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESSION_MODE = 2'd2;

    // compression modes
    localparam logic [CMODE_W-1:0] CMODE_PACKED_RAW  = 3'd2;
    localparam logic [CMODE_W-1:0] CMODE_COMPRESSED  = 3'd3;
    localparam logic [CMODE_W-1:0] CMODE_PACKED_COMP = 3'd4;

    localparam int DIM_RESET = 512;

    // position inside a multi-byte code
    typedef enum logic [2:0] {
        PH_FIRST   = 3'b001,
        PH_SECOND  = 3'b010,
        PH_LITERAL = 3'b100
    } phase_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic [DIM_W-1:0] repeat_count;
        logic             row_done;
        logic             image_done;
    } result_t;

endpackage

// File: src/gpdd_result_fifo.sv
// gpdd_result_fifo: small result queue, takes up to two results a cycle, gives one
// depends on gpdd_pkg
module gpdd_result_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             push_count,
    input  gpdd_pkg::result_t [1:0] push_data,
    output logic                   room,
    output logic                   out_valid,
    input  logic                   out_ready,
    output gpdd_pkg::result_t      out_data
);
    import gpdd_pkg::*;

    result_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  count_reg;
    logic [FIFO_PTR_W-1:0]  wr_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_next;
    logic                   pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a worst-case item of two results
    assign room      = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_count);
    assign count_next  = count_reg + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_data[0];
        end
        if (push_count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= push_data[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: src/genesis_pixel_delta_decoder_top.sv
// genesis_pixel_delta_decoder_top: row and delta decoder of 16-bit image pixels
// depends on gpdd_pkg and gpdd_result_fifo
//
//   channel   handshake                  payload
//   cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
//   item      item_valid / item_ready    mode, row_left, row_span, data_byte
//   result    result_valid / result_ready pixel_value, repeat_count, row_done, image_done
//
// one item per cycle while item_ready is high: each beat is decoded in the cycle it is taken, its 0..2 results
// land in a 4-entry queue and leave it in order on the result port
// results leave at one per cycle while result_ready is high; item_ready is low while fewer than two queue
// entries are free, so the queue drain sets the rate on rows of runs
// cfg_ready is always high; reset clears all state at once, no clearing pass
module genesis_pixel_delta_decoder_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gpdd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gpdd_pkg::DIM_W-1:0]       cfg_data,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic [gpdd_pkg::OP_W-1:0]        mode,
    input  logic [gpdd_pkg::DIM_W-1:0]       row_left,
    input  logic [gpdd_pkg::DIM_W-1:0]       row_span,
    input  logic [gpdd_pkg::BYTE_W-1:0]      data_byte,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [gpdd_pkg::PIX_W-1:0]       pixel_value,
    output logic [gpdd_pkg::DIM_W-1:0]       repeat_count,
    output logic                             row_done,
    output logic                             image_done
);
    import gpdd_pkg::*;

    localparam int DIM_MAX_CODE = (1 << DIM_W) - 1;
    localparam int DIM_CAP      = (MAX_DIM > DIM_MAX_CODE) ? DIM_MAX_CODE : MAX_DIM;
    localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(DIM_CAP);
    localparam logic [DIM_W-1:0] DIM_RESET_EFF =
        DIM_W'((DIM_RESET > DIM_CAP) ? DIM_CAP : DIM_RESET);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_LIMIT)
        begin
            r = DIM_LIMIT;
        end
        return r;
    endfunction

    // configuration, kept already clamped and decoded
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic               packed_reg;
    logic               compressed_reg;

    // decoder state
    logic [PIX_W-1:0]   prev_pixel_reg, prev_pixel_next;
    phase_t             phase_reg, phase_next;
    logic [BYTE_W-1:0]  held_reg, held_next;
    logic [DIM_W-1:0]   col_pos_reg, col_pos_next;
    logic [DIM_W-1:0]   col_end_reg, col_end_next;
    logic [DIM_W-1:0]   row_index_reg, row_index_next;
    logic               row_open_reg, row_open_next;

    logic               item_fire;
    logic               cfg_fire;
    logic [CMODE_W-1:0] cfg_cmode;

    result_t [1:0]      res;
    logic [1:0]         res_count;
    logic [1:0]         push_count;
    logic               closing;
    logic               row_last;
    logic               have_pix;
    logic [PIX_W-1:0]   pix;
    logic [PIX_W-1:0]   delta7;
    logic [PIX_W-1:0]   delta14;
    logic [PIX_W-1:0]   literal_word;
    logic [DIM_W-1:0]   start_col;
    logic [DIM_W-1:0]   end_col;
    logic [DIM_W:0]     end_sum;
    logic               left_run;
    logic [DIM_W-1:0]   col_pos_inc;
    logic               fifo_room;
    result_t            out_data;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign cfg_cmode  = cfg_data[CMODE_W-1:0];
    assign item_ready = fifo_room;
    assign item_fire  = item_valid && item_ready;

    assign delta7       = {{(PIX_W - 7){data_byte[6]}}, data_byte[6:0]};
    assign delta14      = {{3{held_reg[5]}}, held_reg[4:0], data_byte};
    assign literal_word = {held_reg, data_byte};
    assign row_last     = ({1'b0, row_index_reg} + (DIM_W + 1)'(1)) >= {1'b0, height_reg};

    always_comb
    begin
        res             = '0;
        res_count       = 2'd0;
        closing         = 1'b0;
        have_pix        = 1'b0;
        pix             = '0;
        start_col       = '0;
        end_col         = width_reg;
        end_sum         = '0;
        left_run        = 1'b0;
        col_pos_inc     = col_pos_reg + DIM_W'(1);
        prev_pixel_next = prev_pixel_reg;
        phase_next      = phase_reg;
        held_next       = held_reg;
        col_pos_next    = col_pos_reg;
        col_end_next    = col_end_reg;
        row_index_next  = row_index_reg;
        row_open_next   = row_open_reg;

        case (mode)
            OP_IMAGE_START:
            begin
                prev_pixel_next = '0;
                row_index_next  = '0;
                phase_next      = PH_FIRST;
                row_open_next   = 1'b0;
            end
            OP_ROW_START:
            begin
                if (packed_reg)
                begin
                    start_col = (row_left < width_reg) ? row_left : width_reg;
                    end_sum   = {1'b0, start_col} + {1'b0, row_span};
                    end_col   = (end_sum > {1'b0, width_reg}) ? width_reg
                                                              : end_sum[DIM_W-1:0];
                end
                phase_next    = PH_FIRST;
                col_pos_next  = start_col;
                col_end_next  = end_col;
                row_open_next = 1'b1;
                left_run      = (start_col != '0);
                closing       = (start_col >= end_col);
                if (left_run)
                begin
                    res[0].repeat_count = start_col;
                    res_count           = 2'd1;
                end
                // empty stored span: right padding closes the row at once
                if (closing && (end_col < width_reg))
                begin
                    res[left_run].repeat_count = width_reg - end_col;
                    res_count                  = res_count + 2'd1;
                end
            end
            OP_DATA:
            begin
                if (row_open_reg)
                begin
                    if (compressed_reg)
                    begin
                        case (phase_reg)
                            PH_FIRST:
                            begin
                                if (data_byte[7])
                                begin
                                    held_next  = data_byte;
                                    phase_next = PH_SECOND;
                                end
                                else
                                begin
                                    pix      = prev_pixel_reg + delta7;
                                    have_pix = 1'b1;
                                end
                            end
                            PH_SECOND:
                            begin
                                if (held_reg[6])
                                begin
                                    held_next  = data_byte;
                                    phase_next = PH_LITERAL;
                                end
                                else
                                begin
                                    pix        = prev_pixel_reg + delta14;
                                    have_pix   = 1'b1;
                                    phase_next = PH_FIRST;
                                end
                            end
                            default:
                            begin
                                pix        = literal_word;
                                have_pix   = 1'b1;
                                phase_next = PH_FIRST;
                            end
                        endcase
                    end
                    else if (phase_reg == PH_FIRST)
                    begin
                        held_next  = data_byte;
                        phase_next = PH_SECOND;
                    end
                    else
                    begin
                        pix        = literal_word;
                        have_pix   = 1'b1;
                        phase_next = PH_FIRST;
                    end

                    if (have_pix)
                    begin
                        if (compressed_reg)
                        begin
                            prev_pixel_next = pix;
                        end
                        res[0].pixel_value  = pix;
                        res[0].repeat_count = DIM_W'(1);
                        res_count           = 2'd1;
                        col_pos_next        = col_pos_inc;
                        closing             = (col_pos_inc >= col_end_reg);
                        if (closing && (col_end_reg < width_reg))
                        begin
                            res[1].repeat_count = width_reg - col_end_reg;
                            res_count           = 2'd2;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (closing)
        begin
            if (res_count != 2'd0)
            begin
                res[res_count[1]].row_done   = 1'b1;
                res[res_count[1]].image_done = row_last;
            end
            row_index_next = row_last ? '0 : (row_index_reg + DIM_W'(1));
            row_open_next  = 1'b0;
            phase_next     = PH_FIRST;
        end
    end

    assign push_count = item_fire ? res_count : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= DIM_RESET_EFF;
            height_reg     <= DIM_RESET_EFF;
            packed_reg     <= 1'b0;
            compressed_reg <= 1'b0;
            prev_pixel_reg <= '0;
            phase_reg      <= PH_FIRST;
            held_reg       <= '0;
            col_pos_reg    <= '0;
            col_end_reg    <= '0;
            row_index_reg  <= '0;
            row_open_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg <= clamp_dim(cfg_data);
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg <= clamp_dim(cfg_data);
                    end
                    REG_COMPRESSION_MODE:
                    begin
                        packed_reg     <= (cfg_cmode == CMODE_PACKED_RAW) ||
                                          (cfg_cmode == CMODE_PACKED_COMP);
                        compressed_reg <= (cfg_cmode == CMODE_COMPRESSED) ||
                                          (cfg_cmode == CMODE_PACKED_COMP);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (item_fire)
            begin
                prev_pixel_reg <= prev_pixel_next;
                phase_reg      <= phase_next;
                held_reg       <= held_next;
                col_pos_reg    <= col_pos_next;
                col_end_reg    <= col_end_next;
                row_index_reg  <= row_index_next;
                row_open_reg   <= row_open_next;
            end
        end
    end

    gpdd_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_data  (res),
        .room       (fifo_room),
        .out_valid  (result_valid),
        .out_ready  (result_ready),
        .out_data   (out_data)
    );

    assign pixel_value  = out_data.pixel_value;
    assign repeat_count = out_data.repeat_count;
    assign row_done     = out_data.row_done;
    assign image_done   = out_data.image_done;

    // the last result of an image is also the last of its row
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && image_done |-> row_done)
        else $error("image_done without row_done");

    // runs and pixels are never empty
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (repeat_count != '0))
        else $error("zero repeat count");

    // image start restarts the row counter and the predictor
    assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && (mode == OP_IMAGE_START) |=>
            (row_index_reg == '0) && (prev_pixel_reg == '0) && !row_open_reg)
        else $error("image start did not clear state");

    // closing a row always leaves no row open
    assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && closing |=> !row_open_reg && (phase_reg == PH_FIRST))
        else $error("row still open after close");

endmodule
